>>> rtl/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: expression not held");

`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed: consequence not seen next cycle");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

>>> rtl/efp_pkg.sv
package efp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 6;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;

  localparam byte_t SyncByte  = 8'hAA;
  localparam byte_t LenByte   = 8'h20;
  localparam byte_t VerByte   = 8'h02;
  localparam byte_t AttnCode  = 8'h83;
  localparam byte_t AttnLen   = 8'h18;

  localparam pos_t PosSync0   = 6'd0;
  localparam pos_t PosSync1   = 6'd1;
  localparam pos_t PosLen     = 6'd2;
  localparam pos_t PosVer     = 6'd3;
  localparam pos_t PosQuality = 6'd4;
  localparam pos_t PosCode    = 6'd5;
  localparam pos_t PosCodeLen = 6'd6;
  localparam pos_t PosAttn    = 6'd32;
  localparam pos_t PosMed     = 6'd34;
  localparam pos_t PosCsum    = 6'd35;

  localparam int unsigned NumRejected = 9;
  localparam byte_t RejectedQuality [NumRejected] = '{
    8'd29, 8'd54, 8'd55, 8'd56, 8'd80, 8'd81, 8'd82, 8'd107, 8'd200
  };

  function automatic logic quality_rejected(byte_t q);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumRejected; i++) begin
      hit = hit | (q == RejectedQuality[i]);
    end
    return hit;
  endfunction

  function automatic logic byte_matches(pos_t p, byte_t b);
    logic ok;
    case (p) inside
      PosSync0, PosSync1: ok = (b == SyncByte);
      PosLen:             ok = (b == LenByte);
      PosVer:             ok = (b == VerByte);
      PosCode:            ok = (b == AttnCode);
      PosCodeLen:         ok = (b == AttnLen);
      default:            ok = (p < PosCsum);
    endcase
    return ok;
  endfunction

endpackage

>>> rtl/eeg_frame_parser.sv
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   rx_byte_i[7:0]
// output    out        out_valid_o / out_ready_i value_o[7:0], kind_o, last_o
//
// Take one byte per cycle; position, sum and captured levels update at the accepting edge.
// A passing checksum byte loads attention and meditation into the output register
// at its accepting edge; they leave one per output transaction from the next cycle.
// Hold the checksum byte while a result of the last frame waits; take every other
// byte regardless of output stalls.
// Reset clears the position, the sum, the captured bytes and the pending results.
`include "assert_macros.svh"

module eeg_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  efp_pkg::byte_t     rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output efp_pkg::byte_t     value_o,
  output logic               kind_o,
  output logic               last_o
);
  import efp_pkg::*;

  pos_t  pos_q, pos_d;
  byte_t sum_q, sum_d;
  byte_t qual_q, qual_d;
  byte_t attn_q, attn_d;
  byte_t med_q, med_d;

  byte_t res_attn_q, res_attn_d;
  byte_t res_med_q, res_med_d;
  logic  attn_vld_q, attn_vld_d;
  logic  med_vld_q, med_vld_d;

  logic in_fire;
  logic out_fire;
  logic at_csum;
  logic csum_pass;

  assign at_csum    = (pos_q == PosCsum);
  assign in_ready_o = !at_csum || (!attn_vld_q && !med_vld_q);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;
  assign csum_pass  = (rx_byte_i == ~sum_q) && !quality_rejected(qual_q);

  assign out_valid_o = attn_vld_q || med_vld_q;
  assign value_o     = attn_vld_q ? res_attn_q : res_med_q;
  assign kind_o      = !attn_vld_q;
  assign last_o      = !attn_vld_q;

  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    qual_d     = qual_q;
    attn_d     = attn_q;
    med_d      = med_q;
    res_attn_d = res_attn_q;
    res_med_d  = res_med_q;
    attn_vld_d = attn_vld_q;
    med_vld_d  = med_vld_q;

    // drain attention first, then meditation
    if (out_fire) begin
      if (attn_vld_q) begin
        attn_vld_d = 1'b0;
      end else begin
        med_vld_d = 1'b0;
      end
    end

    if (in_fire) begin
      if (at_csum) begin
        pos_d = PosSync0;
        sum_d = '0;
        if (csum_pass) begin
          res_attn_d = attn_q;
          res_med_d  = med_q;
          attn_vld_d = 1'b1;
          med_vld_d  = 1'b1;
        end
      end else if (!byte_matches(pos_q, rx_byte_i)) begin
        pos_d = PosSync0;
        sum_d = '0;
      end else begin
        if (pos_q == PosSync0) begin
          sum_d = '0;
        end else if (pos_q >= PosVer) begin
          sum_d = sum_q + rx_byte_i;
        end
        if (pos_q == PosQuality) begin
          qual_d = rx_byte_i;
        end
        if (pos_q == PosAttn) begin
          attn_d = rx_byte_i;
        end
        if (pos_q == PosMed) begin
          med_d = rx_byte_i;
        end
        pos_d = pos_q + pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= PosSync0;
      sum_q      <= '0;
      qual_q     <= '0;
      attn_q     <= '0;
      med_q      <= '0;
      attn_vld_q <= 1'b0;
      med_vld_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      qual_q     <= qual_d;
      attn_q     <= attn_d;
      med_q      <= med_d;
      attn_vld_q <= attn_vld_d;
      med_vld_q  <= med_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_attn_q <= res_attn_d;
    res_med_q  <= res_med_d;
  end

  `ASSERT_ALWAYS(a_pair_order, clk_i, rst_ni, !attn_vld_q || med_vld_q)
  `ASSERT_ALWAYS(a_pos_range, clk_i, rst_ni, pos_q <= PosCsum)
  `ASSERT_IMPLIES_NEXT(a_pass_loads, clk_i, rst_ni, in_fire && at_csum && csum_pass,
                       out_valid_o && !kind_o)
  `ASSERT_IMPLIES_NEXT(a_med_follows, clk_i, rst_ni, out_fire && !kind_o,
                       out_valid_o && kind_o && last_o)

endmodule
